/* hw/rtl/vnpp_pkg.sv */
`timescale 1ns / 1ps
package vnpp_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF  = 512;
    localparam int unsigned IMAGE_HEIGHT_DEF = 512;

    localparam logic [15:0] SPATIAL_STEP_RST = 16'd3932;
    localparam logic [15:0] TIME_RATE_RST    = 16'd6711;

    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KY = 32'd668265263;
    localparam logic [31:0] HASH_KM = 32'd1274126177;
    localparam logic [8:0]  GAIN_NUM = 9'd292;

    typedef enum logic [0:0] {
        REG_SPATIAL_STEP = 1'b0,
        REG_TIME_RATE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [31:0] time_ms;
    } pix_in_t;

    typedef struct packed {
        logic [8:0] out_x;
        logic [8:0] out_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_out_t;

    // One octave's sample point: 32-bit lattice index and 16-bit fraction per axis.
    typedef struct packed {
        logic [31:0] ix;
        logic [15:0] fx;
        logic [31:0] iy;
        logic [15:0] fy;
    } oct_pt_t;

endpackage

/* hw/rtl/vnpp_octave.sv */
`timescale 1ns / 1ps
// One noise octave as a 5-stage pipeline with a shared stall enable.
module vnpp_octave (
    input  logic                  aclk,
    input  logic                  en,
    input  vnpp_pkg::oct_pt_t     pt,
    output logic [15:0]           noise
);

    // stage 1: corner hash pre-sums, fraction squares
    logic [31:0] hx0_reg, hx1_reg, hy0_reg, hy1_reg;
    logic [31:0] fx2_reg, fy2_reg;
    logic [17:0] kx_reg, ky_reg;
    // stage 2: first hash multiply, smoothstep product
    logic [31:0] m00_reg, m10_reg, m01_reg, m11_reg;
    logic [15:0] ux2_reg, uy2_reg;
    // stage 3: lattice values
    logic [15:0] v00_reg, v10_reg, v01_reg, v11_reg;
    logic [15:0] ux3_reg, uy3_reg;
    // stage 4: row blends
    logic [15:0] row0_reg, row1_reg, uy4_reg;
    // stage 5: column blend
    logic [15:0] n_reg;

    function automatic logic [31:0] mix1(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 13);
        return t * vnpp_pkg::HASH_KM;
    endfunction

    function automatic logic [15:0] mix2(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        return t[15:0];
    endfunction

    function automatic logic [15:0] smooth(input logic [31:0] f2, input logic [17:0] k);
        logic [49:0] p;
        p = {18'd0, f2} * {32'd0, k};
        return p[47:32];
    endfunction

    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] u);
        logic [16:0] ui;
        logic [33:0] s;
        ui = 17'h10000 - {1'b0, u};
        s = {18'd0, a} * {17'd0, ui} + {18'd0, b} * {18'd0, u};
        return s[31:16];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            hx0_reg <= pt.ix * vnpp_pkg::HASH_KX;
            hx1_reg <= (pt.ix + 32'd1) * vnpp_pkg::HASH_KX;
            hy0_reg <= pt.iy * vnpp_pkg::HASH_KY;
            hy1_reg <= (pt.iy + 32'd1) * vnpp_pkg::HASH_KY;
            fx2_reg <= {16'd0, pt.fx} * {16'd0, pt.fx};
            fy2_reg <= {16'd0, pt.fy} * {16'd0, pt.fy};
            kx_reg  <= 18'd196608 - {1'b0, pt.fx, 1'b0};
            ky_reg  <= 18'd196608 - {1'b0, pt.fy, 1'b0};

            m00_reg <= mix1(hx0_reg + hy0_reg);
            m10_reg <= mix1(hx1_reg + hy0_reg);
            m01_reg <= mix1(hx0_reg + hy1_reg);
            m11_reg <= mix1(hx1_reg + hy1_reg);
            ux2_reg <= smooth(fx2_reg, kx_reg);
            uy2_reg <= smooth(fy2_reg, ky_reg);

            v00_reg <= mix2(m00_reg);
            v10_reg <= mix2(m10_reg);
            v01_reg <= mix2(m01_reg);
            v11_reg <= mix2(m11_reg);
            ux3_reg <= ux2_reg;
            uy3_reg <= uy2_reg;

            row0_reg <= lerp(v00_reg, v10_reg, ux3_reg);
            row1_reg <= lerp(v01_reg, v11_reg, ux3_reg);
            uy4_reg  <= uy3_reg;

            n_reg <= lerp(row0_reg, row1_reg, uy4_reg);
        end
    end

    assign noise = n_reg;

endmodule

/* hw/rtl/value_noise_palette_pixel.sv */
`timescale 1ns / 1ps
// Animated value-noise pixel generator. Each input beat carries a pixel coordinate and a
// time in milliseconds; the matching output beat carries the same coordinate and its RGB
// colour from a three-octave value noise mapped to a blue-to-white palette. One pixel is
// accepted per clock and the pipeline is fully stalled by m_ready, so throughput drops
// only when the sink holds off. Pixels outside IMAGE_WIDTH x IMAGE_HEIGHT are accepted and
// dropped. The user must write spatial_step (0x0) and time_rate (0x4) through the APB port
// only while no pixel is in flight; the block itself does not enforce this.
module value_noise_palette_pixel #(
    parameter int unsigned IMAGE_WIDTH  = vnpp_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = vnpp_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vnpp_pkg::pix_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vnpp_pkg::pix_out_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = 9;

    logic [15:0] spatial_step_reg, time_rate_reg;
    logic        wr_en;
    vnpp_pkg::reg_idx_t ridx;

    assign pready = 1'b1;
    assign ridx   = vnpp_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'd0);

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spatial_step_reg <= vnpp_pkg::SPATIAL_STEP_RST;
            time_rate_reg    <= vnpp_pkg::TIME_RATE_RST;
        end else if (wr_en) begin
            case (ridx)
                vnpp_pkg::REG_SPATIAL_STEP: spatial_step_reg <= pwdata[15:0];
                vnpp_pkg::REG_TIME_RATE:    time_rate_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            vnpp_pkg::REG_SPATIAL_STEP: prdata = {16'd0, spatial_step_reg};
            vnpp_pkg::REG_TIME_RATE:    prdata = {16'd0, time_rate_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Whole pipeline advances together; a stall holds every stage.
    logic en;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [8:0] px_reg [DEPTH];
    logic [8:0] py_reg [DEPTH];
    logic in_range;

    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign m_valid  = vld_reg[DEPTH-1];
    assign in_range = ({23'd0, s_data.pixel_x} < IMAGE_WIDTH) &&
                      ({23'd0, s_data.pixel_y} < IMAGE_HEIGHT);

    always_comb begin
        vld_next = {vld_reg[DEPTH-2:0], s_valid && in_range};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= s_data.pixel_x;
            py_reg[0] <= s_data.pixel_y;
            for (int i = 1; i < DEPTH; i++) begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
            end
        end
    end

    // Stage 1: scale coordinates (Q16) and time (Q24).
    logic [24:0] x_reg, y_reg;
    logic [47:0] tp_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= {16'd0, s_data.pixel_x} * {9'd0, spatial_step_reg};
            y_reg  <= {16'd0, s_data.pixel_y} * {9'd0, spatial_step_reg};
            tp_reg <= {16'd0, s_data.time_ms} * {32'd0, time_rate_reg};
        end
    end

    // Stage 2: octave sample coordinates, 50 bits to keep index wrap exact.
    logic [39:0] t1;
    logic [49:0] c1x_reg, c2x_reg, c3x_reg;
    logic [26:0] c1y_reg, c2y_reg, c3y_reg;
    assign t1 = tp_reg[47:8];
    always_ff @(posedge aclk) begin
        if (en) begin
            c1x_reg <= {25'd0, x_reg} + {10'd0, t1};
            c2x_reg <= {24'd0, x_reg, 1'b0} + {10'd0, t1} + {11'd0, t1[39:1]};
            c3x_reg <= {23'd0, x_reg, 2'b0} + {9'd0, t1, 1'b0};
            c1y_reg <= {2'd0, y_reg};
            c2y_reg <= {1'd0, y_reg, 1'b0};
            c3y_reg <= {y_reg, 2'b0};
        end
    end

    vnpp_pkg::oct_pt_t p1, p2, p3;
    assign p1 = '{ix: c1x_reg[47:16], fx: c1x_reg[15:0],
                  iy: {21'd0, c1y_reg[26:16]}, fy: c1y_reg[15:0]};
    assign p2 = '{ix: c2x_reg[47:16], fx: c2x_reg[15:0],
                  iy: {21'd0, c2y_reg[26:16]}, fy: c2y_reg[15:0]};
    assign p3 = '{ix: c3x_reg[47:16], fx: c3x_reg[15:0],
                  iy: {21'd0, c3y_reg[26:16]}, fy: c3y_reg[15:0]};

    // Stages 3-7: three octaves in parallel.
    logic [15:0] n1, n2, n3;
    vnpp_octave u_oct1 (.aclk(aclk), .en(en), .pt(p1), .noise(n1));
    vnpp_octave u_oct2 (.aclk(aclk), .en(en), .pt(p2), .noise(n2));
    vnpp_octave u_oct3 (.aclk(aclk), .en(en), .pt(p3), .noise(n3));

    // Stage 8: weighted sum and gain, saturate to one.
    logic [18:0] s_sum;
    logic [27:0] s_gain;
    logic [16:0] g_reg, g_raw;
    assign s_sum  = {1'b0, n1, 2'b0} + {2'b0, n2, 1'b0} + {3'b0, n3};
    assign s_gain = {9'd0, s_sum} * {19'd0, vnpp_pkg::GAIN_NUM};
    assign g_raw  = s_gain[27:11];
    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg <= (g_raw > 17'h10000) ? 17'h10000 : g_raw;
        end
    end

    // Stage 9: palette segment and interpolation.
    logic        hi;
    logic [16:0] w;
    logic [7:0]  r_next, gr_next, b_next;
    logic [7:0]  r_reg, gr_reg, b_reg;
    logic [24:0] pr, pg, pb;
    assign hi = g_reg[16] || g_reg[15];
    assign w  = hi ? {g_reg[15:0], 1'b0} - 17'h10000 : {g_reg[15:0], 1'b0};
    always_comb begin
        if (hi) begin
            pr = {8'd0, w} * 25'd190;
            pg = {8'd0, w} * 25'd130;
            pb = {8'd0, w} * 25'd75;
            r_next  = 8'd30  + pr[23:16];
            gr_next = 8'd100 + pg[23:16];
            b_next  = 8'd180 + pb[23:16];
        end else begin
            pr = {8'd0, w} * 25'd20;
            pg = {8'd0, w} * 25'd80;
            pb = {8'd0, w} * 25'd100;
            r_next  = 8'd10 + pr[23:16];
            gr_next = 8'd20 + pg[23:16];
            b_next  = 8'd80 + pb[23:16];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg  <= r_next;
            gr_reg <= gr_next;
            b_reg  <= b_next;
        end
    end

    assign m_data = '{out_x: px_reg[DEPTH-1], out_y: py_reg[DEPTH-1],
                      red: r_reg, green: gr_reg, blue: b_reg};

    // Assertions
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed during stall");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && in_range && m_ready && $past(m_ready) |-> ##0 1'b1 ##1 vld_reg[0])
        else $error("accepted pixel not entered");
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !in_range |=> !vld_reg[0])
        else $error("out-of-range pixel entered pipeline");
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        g_reg <= 17'h10000)
        else $error("gain not saturated");

endmodule
